@@ design/bbs_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bbs_pkg
// Shared types and constants for the Blum Blum Shub sequence generator.
// ----------------------------------------------------------------------------
package bbs_pkg;

   localparam int FACTOR_BITS = 16;
   localparam int MAX_RUN     = 64;

   localparam int SEED_BITS   = 32;
   localparam int RUN_BITS    = 7;
   localparam int VALUE_BITS  = 32;
   localparam int CSR_BITS    = FACTOR_BITS;
   localparam int CSR_IDX_BITS = 1;

   localparam int MOD_BITS    = 2 * FACTOR_BITS;
   localparam int PROD_BITS   = 2 * MOD_BITS;
   localparam int LO_BITS     = (SEED_BITS > MOD_BITS) ? SEED_BITS : MOD_BITS;
   localparam int CNT_BITS    = $clog2(LO_BITS + 1);

   localparam logic [FACTOR_BITS-1:0] PRIME_P_RESET = FACTOR_BITS'(7);
   localparam logic [FACTOR_BITS-1:0] PRIME_Q_RESET = FACTOR_BITS'(11);

   localparam logic [CSR_IDX_BITS-1:0] CSR_PRIME_P = CSR_IDX_BITS'(0);
   localparam logic [CSR_IDX_BITS-1:0] CSR_PRIME_Q = CSR_IDX_BITS'(1);

   typedef struct packed {
      logic [SEED_BITS-1:0] seed;
      logic [RUN_BITS-1:0]  run_length;
   } req_payload_type;

   typedef struct packed {
      logic [VALUE_BITS-1:0] value;
      logic                  last;
      logic                  bad_modulus;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MODULUS,
      ST_SETUP,
      ST_REDUCE,
      ST_SQUARE,
      ST_EMIT
   } state_type;

endpackage
`default_nettype wire

@@ design/bbs_sequence_generator_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bbs_sequence_generator_top
// Blum Blum Shub generator: one seed and run length in, a run of squares
// mod p*q out, built on one multiplier and one bit-serial restoring reducer.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake          Beat
//  req      in         req_valid/stall    seed, run_length
//  rsp      out        rsp_valid/stall    value, last, bad_modulus
//  csr      in         csr_wr_en          prime_p / prime_q write
//
//  A run passes through the accept, one multiply for the modulus, a setup step,
//  a 32-step reduction of the seed, then per value one squaring, 32 restoring
//  steps and one output step; if M < 2 the setup goes straight to output.
//  req_stall is high from the cycle after acceptance of a nonzero run until
//  the final value enters the output register; output register stalls hold
//  the output state. Reset is synchronous; the factors return to 7 and 11.
// ----------------------------------------------------------------------------
module bbs_sequence_generator_top (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_stall,
   input  wire bbs_pkg::req_payload_type req_data,
   output logic                         rsp_valid,
   input  wire                          rsp_stall,
   output bbs_pkg::rsp_payload_type     rsp_data,
   input  wire                          csr_wr_en,
   input  wire [bbs_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  wire [bbs_pkg::CSR_BITS-1:0]  csr_wdata
);
   import bbs_pkg::*;

   state_type                state_ff, state_in;
   logic [FACTOR_BITS-1:0]   prime_p_ff, prime_q_ff;
   logic [SEED_BITS-1:0]     seed_ff, seed_in;
   logic [RUN_BITS-1:0]      left_ff, left_in;
   logic [MOD_BITS-1:0]      m_ff, m_in;
   logic                     bad_ff, bad_in;
   logic                     seed_phase_ff, seed_phase_in;
   logic [MOD_BITS-1:0]      rem_ff, rem_in;
   logic [LO_BITS-1:0]       lo_ff, lo_in;
   logic [CNT_BITS-1:0]      cnt_ff, cnt_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_payload_type          rsp_data_ff, rsp_data_in;

   logic [RUN_BITS-1:0]      run_sat;
   logic [MOD_BITS-1:0]      mul_a, mul_b;
   logic [PROD_BITS-1:0]     prod;
   logic [MOD_BITS:0]        trial, m_ext;
   logic                     out_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign run_sat  = (req_data.run_length > RUN_BITS'(MAX_RUN)) ? RUN_BITS'(MAX_RUN)
                                                                 : req_data.run_length;
   assign mul_a    = (state_ff == ST_MODULUS) ? MOD_BITS'(prime_p_ff) : rem_ff;
   assign mul_b    = (state_ff == ST_MODULUS) ? MOD_BITS'(prime_q_ff) : rem_ff;
   assign prod     = PROD_BITS'(mul_a) * PROD_BITS'(mul_b);
   assign m_ext    = {1'b0, m_ff};
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         prime_p_ff <= PRIME_P_RESET;
         prime_q_ff <= PRIME_Q_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_PRIME_P: prime_p_ff <= csr_wdata[FACTOR_BITS-1:0];
            CSR_PRIME_Q: prime_q_ff <= csr_wdata[FACTOR_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         left_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         left_ff      <= left_in;
      end
   end

   always_ff @(posedge clock) begin
      seed_ff       <= seed_in;
      m_ff          <= m_in;
      bad_ff        <= bad_in;
      seed_phase_ff <= seed_phase_in;
      rem_ff        <= rem_in;
      lo_ff         <= lo_in;
      cnt_ff        <= cnt_in;
      rsp_data_ff   <= rsp_data_in;
   end

   always_comb begin
      state_in      = state_ff;
      seed_in       = seed_ff;
      left_in       = left_ff;
      m_in          = m_ff;
      bad_in        = bad_ff;
      seed_phase_in = seed_phase_ff;
      rem_in        = rem_ff;
      lo_in         = lo_ff;
      cnt_in        = cnt_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;
      trial         = {rem_ff, lo_ff[LO_BITS-1]};
      if (trial >= m_ext) begin
         trial = trial - m_ext;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               seed_in = req_data.seed;
               left_in = run_sat;
               if (run_sat != '0) begin
                  state_in = ST_MODULUS;
               end
            end
         end
         ST_MODULUS: begin
            m_in     = prod[MOD_BITS-1:0];
            state_in = ST_SETUP;
         end
         ST_SETUP: begin
            bad_in        = (m_ff < MOD_BITS'(2));
            rem_in        = '0;
            lo_in         = LO_BITS'(seed_ff);
            cnt_in        = CNT_BITS'(LO_BITS);
            seed_phase_in = 1'b1;
            state_in      = (m_ff < MOD_BITS'(2)) ? ST_EMIT : ST_REDUCE;
         end
         ST_REDUCE: begin
            rem_in = trial[MOD_BITS-1:0];
            lo_in  = lo_ff << 1;
            cnt_in = cnt_ff - CNT_BITS'(1);
            if (cnt_ff == CNT_BITS'(1)) begin
               state_in = seed_phase_ff ? ST_SQUARE : ST_EMIT;
            end
         end
         ST_SQUARE: begin
            rem_in        = prod[PROD_BITS-1:MOD_BITS];
            lo_in         = LO_BITS'(prod[MOD_BITS-1:0]) << (LO_BITS - MOD_BITS);
            cnt_in        = CNT_BITS'(MOD_BITS);
            seed_phase_in = 1'b0;
            state_in      = ST_REDUCE;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.value       = bad_ff ? '0 : VALUE_BITS'(rem_ff);
               rsp_data_in.last        = (left_ff == RUN_BITS'(1));
               rsp_data_in.bad_modulus = bad_ff;
               left_in                 = left_ff - RUN_BITS'(1);
               if (left_ff == RUN_BITS'(1)) begin
                  state_in = ST_IDLE;
               end else if (bad_ff) begin
                  state_in = ST_EMIT;
               end else begin
                  state_in = ST_SQUARE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.run_length != '0 |=> req_stall)
      else $error("block not busy after accepting a nonzero run");

   a_residue_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT && !bad_ff |-> rem_ff < m_ff)
      else $error("residue not below modulus at output");

   a_bad_value_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.bad_modulus |-> rsp_data.value == '0)
      else $error("bad modulus beat carries nonzero value");

   a_run_count_live: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> left_ff != '0)
      else $error("run count exhausted while busy");

endmodule
`default_nettype wire
